// ----- src/system_control_coprocessor_regs_macros.svh -----
// Assertion macros for the system control coprocessor register block.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef SYSTEM_CONTROL_COPROCESSOR_REGS_MACROS_SVH
`define SYSTEM_CONTROL_COPROCESSOR_REGS_MACROS_SVH

// Same-cycle implication.
`define SCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scc assertion failed");

// Next-cycle implication.
`define SCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scc assertion failed");

`endif

// ----- src/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Types, register codes and region arithmetic shared by the coprocessor
// register block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    localparam logic [31:0] IdWord        = 32'h4105_9461;
    localparam logic [31:0] CacheTypeWord = 32'h0F0D_2112;
    localparam logic [31:0] BaseMask      = 32'hFFFF_F000;
    localparam logic [31:0] LowMask       = 32'h0000_0FFF;
    localparam logic [31:0] MinUnit       = 32'd512;
    localparam logic [4:0]  SizeLow       = 5'd3;
    localparam logic [4:0]  SizeHigh      = 5'd23;
    localparam logic [31:0] DataReset     = 32'h0080_000A;
    localparam logic [31:0] InstrReset    = 32'h0000_000C;

    // Access kinds and register selects
    localparam logic       OpRead       = 1'b0;
    localparam logic       OpWrite      = 1'b1;
    localparam logic [2:0] Op1System    = 3'd0;
    localparam logic [3:0] CrnId        = 4'd0;
    localparam logic [3:0] CrmId        = 4'd0;
    localparam logic [3:0] CrnTcm       = 4'd9;
    localparam logic [3:0] CrmTcm       = 4'd1;
    localparam logic [2:0] Op2Id        = 3'd0;
    localparam logic [2:0] Op2CacheType = 3'd1;
    localparam logic [2:0] Op2Data      = 3'd0;
    localparam logic [2:0] Op2Instr     = 3'd1;

    typedef struct packed {
        logic        operation;
        logic [2:0]  opcode_one;
        logic [3:0]  reg_primary;
        logic [3:0]  reg_secondary;
        logic [2:0]  opcode_two;
        logic [31:0] write_value;
    } access_t;

    typedef struct packed {
        logic        limit_wrap_error;
        logic        base_write_error;
        logic        size_error;
        logic [31:0] instr_region_limit;
        logic [31:0] data_region_limit;
        logic [31:0] data_region_base;
        logic [31:0] read_data;
    } result_t;

    function automatic logic [4:0] size_code(input logic [31:0] word);
        size_code = word[5:1];
    endfunction

    // Last address: base + 2^(size+9) - 1, all modulo 2^32
    function automatic logic [31:0] region_limit(input logic [31:0] word);
        logic [31:0] span;
        span = MinUnit << size_code(word);
        region_limit = (word & BaseMask) + span - 32'd1;
    endfunction

endpackage

`default_nettype wire

// ----- src/scc_region_unit.sv -----
// ----------------------------------------------------------------------------
// scc_region_unit
// Region word registers, access decode and result computation for one
// coprocessor access; state advances on commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scc_region_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire scc_pkg::access_t  access,
    input  wire logic              commit,
    output scc_pkg::result_t       result
);

    logic [31:0] data_word_reg, data_word_next;
    logic [31:0] instr_word_reg, instr_word_next;

    logic        sys_sel;
    logic        id_sel;
    logic        tcm_sel;
    logic        is_write;
    logic [31:0] wr_word;
    logic        base_err;
    logic [4:0]  wr_size;
    logic [31:0] wr_limit;
    logic [31:0] rd_value;

    always_comb begin
        sys_sel  = (access.opcode_one == scc_pkg::Op1System);
        id_sel   = sys_sel && (access.reg_primary == scc_pkg::CrnId)
                   && (access.reg_secondary == scc_pkg::CrmId);
        tcm_sel  = sys_sel && (access.reg_primary == scc_pkg::CrnTcm)
                   && (access.reg_secondary == scc_pkg::CrmTcm)
                   && ((access.opcode_two == scc_pkg::Op2Data)
                       || (access.opcode_two == scc_pkg::Op2Instr));
        is_write = (access.operation == scc_pkg::OpWrite);

        // Instruction base is hardwired to zero: keep only the low bits
        base_err = (access.opcode_two == scc_pkg::Op2Instr)
                   && ((access.write_value & scc_pkg::BaseMask) != 32'd0);
        wr_word  = base_err ? (access.write_value & scc_pkg::LowMask) : access.write_value;
        wr_size  = scc_pkg::size_code(wr_word);
        wr_limit = scc_pkg::region_limit(wr_word);

        rd_value = 32'd0;
        if (!is_write) begin
            if (id_sel) begin
                if (access.opcode_two == scc_pkg::Op2Id) begin
                    rd_value = scc_pkg::IdWord;
                end else if (access.opcode_two == scc_pkg::Op2CacheType) begin
                    rd_value = scc_pkg::CacheTypeWord;
                end
            end else if (tcm_sel) begin
                rd_value = (access.opcode_two == scc_pkg::Op2Data) ? data_word_reg
                                                                    : instr_word_reg;
            end
        end

        data_word_next  = data_word_reg;
        instr_word_next = instr_word_reg;
        if (tcm_sel && is_write) begin
            if (access.opcode_two == scc_pkg::Op2Data) begin
                data_word_next = wr_word;
            end else begin
                instr_word_next = wr_word;
            end
        end

        result.read_data          = rd_value;
        result.data_region_base   = data_word_next & scc_pkg::BaseMask;
        result.data_region_limit  = scc_pkg::region_limit(data_word_next);
        result.instr_region_limit =
            scc_pkg::region_limit(instr_word_next & scc_pkg::LowMask);
        result.size_error         = tcm_sel && is_write
                                    && ((wr_size < scc_pkg::SizeLow)
                                        || (wr_size > scc_pkg::SizeHigh));
        result.base_write_error   = tcm_sel && is_write && base_err;
        result.limit_wrap_error   = tcm_sel && is_write
                                    && (wr_limit < (wr_word & scc_pkg::BaseMask));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_word_reg  <= scc_pkg::DataReset;
            instr_word_reg <= scc_pkg::InstrReset;
        end else if (commit) begin
            data_word_reg  <= data_word_next;
            instr_word_reg <= instr_word_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/system_control_coprocessor_regs.sv -----
// ----------------------------------------------------------------------------
// system_control_coprocessor_regs
// Coprocessor access port for the tightly coupled memory region registers
// and the identification words.
//
//   channel  dir  tdata bits  tuser  meaning
//   s_       in   48          1      one coprocessor access
//   m_       out  136         -      read value, region bounds, error flags
//
// An access passes through the input register and then the result register.
// One access per cycle is sustained while the result side is ready; the
// region add and compare sit between the two registers.
// Reset restores both region words and empties both registers.
// A stalled result holds; the input register still fills behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module system_control_coprocessor_regs (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [2:0] opcode_one, [6:3] reg_primary, [10:7] reg_secondary,
    // [13:11] opcode_two, [45:14] write_value, [47:46] zero
    input  wire logic [47:0]  s_tdata,
    // [0] operation
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] read_data, [63:32] data_region_base, [95:64] data_region_limit,
    // [127:96] instr_region_limit, [128] size_error, [129] base_write_error,
    // [130] limit_wrap_error, [135:131] zero
    output logic [135:0]      m_tdata
);

`include "system_control_coprocessor_regs_macros.svh"

    logic              in_valid_reg;
    scc_pkg::access_t  in_data_reg;
    logic              out_valid_reg, out_valid_next;
    scc_pkg::result_t  out_data_reg;
    scc_pkg::result_t  result;
    logic              advance;
    logic              s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg.operation     <= s_tuser[0];
            in_data_reg.opcode_one    <= s_tdata[2:0];
            in_data_reg.reg_primary   <= s_tdata[6:3];
            in_data_reg.reg_secondary <= s_tdata[10:7];
            in_data_reg.opcode_two    <= s_tdata[13:11];
            in_data_reg.write_value   <= s_tdata[45:14];
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    scc_region_unit u_region (
        .aclk    (aclk),
        .aresetn (aresetn),
        .access  (in_data_reg),
        .commit  (advance),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg};

    // A wrapped limit can only come from a data region write
    `SCC_ASSERT_SAME(a_wrap_consistent, m_tvalid && out_data_reg.limit_wrap_error, out_data_reg.data_region_limit < out_data_reg.data_region_base)
    `SCC_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg)
    `SCC_ASSERT_NEXT(a_input_holds, in_valid_reg && !advance, in_valid_reg && $stable(in_data_reg))
    `SCC_ASSERT_SAME(a_base_err_write, m_tvalid && out_data_reg.base_write_error, out_data_reg.read_data == 32'd0)

endmodule

`default_nettype wire

// ----- tb/system_control_coprocessor_regs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// system_control_coprocessor_regs_checker
// Watches both stream channels of the coprocessor register block. It keeps
// its own copy of the two region words, works out the result of every access
// the block takes in, and compares each result transfer field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module system_control_coprocessor_regs_checker
    import scc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [47:0]  s_tdata,
    input  wire logic [0:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [135:0] m_tdata,
    output int unsigned       mismatch_count,
    output int unsigned       pending_results,
    output int unsigned       results_checked,
    output int unsigned       size_flags,
    output int unsigned       base_flags,
    output int unsigned       wrap_flags
);

    logic [31:0] data_word;
    logic [31:0] instr_word;
    result_t     expected_results[$];

    // Span is formed in 64 bits and cut back, so sizes 23 and up add nothing
    function automatic logic [31:0] last_address(input logic [31:0] word);
        logic [63:0] span;
        span = {32'd0, MinUnit} << word[5:1];
        last_address = (word & BaseMask) + span[31:0] - 32'd1;
    endfunction

    // Apply one access to the region words and return what the block reports
    function automatic result_t apply_access(input logic wr, input logic [2:0] op1,
                                             input logic [3:0] crn, input logic [3:0] crm,
                                             input logic [2:0] op2,
                                             input logic [31:0] value);
        result_t     res;
        logic [31:0] word;
        res = '0;
        if (op1 == Op1System) begin
            if (crn == CrnId && crm == CrmId) begin
                if (wr == OpRead) begin
                    if (op2 == Op2Id)
                        res.read_data = IdWord;
                    else if (op2 == Op2CacheType)
                        res.read_data = CacheTypeWord;
                end
            end else if (crn == CrnTcm && crm == CrmTcm && (op2 == Op2Data || op2 == Op2Instr)) begin
                if (wr == OpRead) begin
                    res.read_data = (op2 == Op2Data) ? data_word : instr_word;
                end else begin
                    word = value;
                    // Instruction base is hardwired to zero: drop the upper bits
                    if (op2 == Op2Instr && (word & BaseMask) != 32'd0) begin
                        word = word & LowMask;
                        res.base_write_error = 1'b1;
                    end
                    res.size_error = (word[5:1] < SizeLow) || (word[5:1] > SizeHigh);
                    res.limit_wrap_error = last_address(word) < (word & BaseMask);
                    if (op2 == Op2Data)
                        data_word = word;
                    else
                        instr_word = word;
                end
            end
        end
        res.data_region_base   = data_word & BaseMask;
        res.data_region_limit  = last_address(data_word);
        res.instr_region_limit = last_address(instr_word & LowMask);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            data_word  = DataReset;
            instr_word = InstrReset;
            expected_results.delete();
            mismatch_count  = 0;
            results_checked = 0;
            size_flags      = 0;
            base_flags      = 0;
            wrap_flags      = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_access(s_tuser[0], s_tdata[2:0],
                    s_tdata[6:3], s_tdata[10:7], s_tdata[13:11], s_tdata[45:14]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[130:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no access outstanding, expected none actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("data_region_base", want.data_region_base,
                                got.data_region_base);
                    check_field("data_region_limit", want.data_region_limit,
                                got.data_region_limit);
                    check_field("instr_region_limit", want.instr_region_limit,
                                got.instr_region_limit);
                    check_field("size_error", want.size_error, got.size_error);
                    check_field("base_write_error", want.base_write_error,
                                got.base_write_error);
                    check_field("limit_wrap_error", want.limit_wrap_error,
                                got.limit_wrap_error);
                    results_checked++;
                    size_flags += want.size_error;
                    base_flags += want.base_write_error;
                    wrap_flags += want.limit_wrap_error;
                end
            end
        end
        pending_results <= expected_results.size();
    end

endmodule

// ----- tb/system_control_coprocessor_regs_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// system_control_coprocessor_regs_test
// Drives coprocessor accesses into the register block: a directed pass over
// the identification words, region writes with bad sizes, wrapped limits and
// nonzero instruction bases, then random traffic weighted toward the region
// registers under three idling patterns and one long result stall.
// ----------------------------------------------------------------------------
module system_control_coprocessor_regs_test;
    import scc_pkg::*;

    localparam int unsigned StallLimit     = 2000;
    localparam int unsigned HoldOffCycles  = 300;
    localparam int unsigned RandomPerPhase = 400;
    localparam int unsigned DrainCycles    = 8;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    wire          s_tready;
    logic [47:0]  s_tdata;
    logic [0:0]   s_tuser;
    wire          m_tvalid;
    logic         m_tready;
    wire  [135:0] m_tdata;

    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;
    int unsigned  hold_requests;
    int unsigned  idle_cycles;

    int unsigned  mismatch_count;
    int unsigned  pending_results;
    int unsigned  results_checked;
    int unsigned  size_flags;
    int unsigned  base_flags;
    int unsigned  wrap_flags;

    system_control_coprocessor_regs u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    system_control_coprocessor_regs_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .size_flags      (size_flags),
        .base_flags      (base_flags),
        .wrap_flags      (wrap_flags)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: random back-pressure, plus a long hold-off on request
    initial begin
        int unsigned hold_left;
        int unsigned holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (holds_taken != hold_requests) begin
                holds_taken++;
                hold_left = HoldOffCycles;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count
    initial begin
        idle_cycles = 0;
        while (idle_cycles < StallLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_access(input logic wr, input logic [2:0] op1,
                               input logic [3:0] crn, input logic [3:0] crm,
                               input logic [2:0] op2, input logic [31:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, value, op2, crm, crn, op1};
        s_tuser  <= wr;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic send_random_batch(input int unsigned count);
        int unsigned pick;
        logic        wr;
        logic [2:0]  op1;
        logic [3:0]  crn;
        logic [3:0]  crm;
        logic [2:0]  op2;
        logic [31:0] value;
        for (int unsigned n = 0; n < count; n++) begin
            pick  = $urandom_range(99);
            wr    = 1'($urandom_range(1));
            op1   = Op1System;
            crn   = CrnTcm;
            crm   = CrmTcm;
            op2   = 3'($urandom_range(1));
            value = $urandom;
            if (pick < 60) begin
                case ($urandom_range(4))
                    0: ;
                    1: value = (value & ~32'h3E) | ($urandom_range(SizeHigh, SizeLow) << 1);
                    // high base with a large size: limit tends to wrap
                    2: value = ((value | 32'hF000_0000) & ~32'h3E) | ($urandom_range(31, 18) << 1);
                    3: value = value & LowMask;
                    default: value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                endcase
            end else if (pick < 75) begin
                crn = CrnId;
                crm = CrmId;
                op2 = 3'($urandom_range(7));
            end else begin
                op1 = 3'($urandom_range(7));
                crn = 4'($urandom_range(15));
                crm = 4'($urandom_range(15));
                op2 = 3'($urandom_range(7));
            end
            send_access(wr, op1, crn, crm, op2, value);
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_requests = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identification words and their unmapped neighbors
        send_access(OpRead,  Op1System, CrnId, CrmId, Op2Id, 32'h0);
        send_access(OpRead,  Op1System, CrnId, CrmId, Op2CacheType, 32'h0);
        send_access(OpRead,  Op1System, CrnId, CrmId, 3'd7, 32'h0);
        send_access(OpWrite, Op1System, CrnId, CrmId, Op2Id, 32'hFFFF_FFFF);
        // Region words straight out of reset
        send_access(OpRead,  Op1System, CrnTcm, CrmTcm, Op2Data, 32'h0);
        send_access(OpRead,  Op1System, CrnTcm, CrmTcm, Op2Instr, 32'h0);
        // Data region: legal size, size zero, size 31, size 23, 2 GiB up to the top without wrap, all ones
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Data, 32'h1234_5014);
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Data, 32'h0000_0000);
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Data, 32'hABCD_E03E);
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Data, 32'h0010_002E);
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Data, 32'h8000_002C);
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Data, 32'hFFFF_FFFF);
        // Instruction region: nonzero base dropped, then low-bit-only words
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Instr, 32'hFFFF_F006);
        send_access(OpRead,  Op1System, CrnTcm, CrmTcm, Op2Instr, 32'h0);
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Instr, 32'h0000_0FFF);
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, Op2Instr, 32'h0000_0010);
        send_access(OpRead,  Op1System, CrnTcm, CrmTcm, Op2Data, 32'h0);
        // Nonzero opcode one and unmapped registers leave the state alone
        send_access(OpWrite, 3'd7, CrnTcm, CrmTcm, Op2Data, 32'h5555_5000);
        send_access(OpRead,  3'd7, CrnTcm, CrmTcm, Op2Data, 32'h0);
        send_access(OpWrite, Op1System, 4'd15, 4'd15, 3'd7, 32'hFFFF_FFFF);
        send_access(OpRead,  Op1System, 4'd15, 4'd15, 3'd7, 32'h0);
        send_access(OpWrite, Op1System, CrnTcm, CrmTcm, 3'd7, 32'h0000_0000);
        send_access(OpRead,  Op1System, CrnTcm, CrmTcm, 3'd7, 32'h0);
        send_access(OpRead,  Op1System, CrnTcm, CrmTcm, Op2Data, 32'h0);

        tx_idle_pct = 29;
        rx_idle_pct = 81;
        send_random_batch(RandomPerPhase);
        tx_idle_pct = 81;
        rx_idle_pct = 29;
        send_random_batch(RandomPerPhase);
        // Full rate; stall the result side long enough to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        send_random_batch(RandomPerPhase);
        s_tvalid <= 1'b0;

        do begin
            @(posedge aclk);
        end while (pending_results != 0);
        repeat (DrainCycles) @(posedge aclk);

        $display("Checked %0d coprocessor accesses over directed, idling and stall phases.",
                 results_checked);
        $display("Error flags seen: size %0d, instruction base %0d, limit wrap %0d.",
                 size_flags, base_flags, wrap_flags);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- system_control_coprocessor_regs.f -----
+incdir+src
src/scc_pkg.sv
src/scc_region_unit.sv
src/system_control_coprocessor_regs.sv
tb/system_control_coprocessor_regs_checker.sv
tb/system_control_coprocessor_regs_test.sv
